// File: rtl/swrl_pkg.sv
// shared types and constants of the sliding window rate limiter
`default_nettype none

package swrl_pkg;

  // field and register widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned OCC_W     = 7;
  localparam int unsigned OCC_BUS_W = 8;
  localparam int unsigned MAX_W     = 7;
  localparam int unsigned WIN_W     = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  // reset values of the configuration registers
  localparam logic [MAX_W-1:0] MAX_RESET = 7'd64;
  localparam logic [WIN_W-1:0] WIN_RESET = 32'd1000000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_PER_WINDOW = 8'd0,
    REG_WINDOW_TICKS   = 8'd1
  } cfg_reg_e;

  // request sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_EXPIRE = 2'b10
  } state_e;

  // per-cell control: shift toward the oldest end, or load a new stamp
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/swrl_cell.sv
// one stamp cell of the shifting stamp chain
`default_nettype none

module swrl_cell #(
  parameter int unsigned STAMP_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire swrl_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic [STAMP_BITS-1:0]  next_stamp_i,  // from the younger neighbor
  input  wire logic [STAMP_BITS-1:0]  load_stamp_i,
  output logic      [STAMP_BITS-1:0]  stamp_o
);

  logic [STAMP_BITS-1:0] stamp_q, stamp_d;

  always_comb begin
    stamp_d = stamp_q;
    if (ctrl_i.shift) begin
      stamp_d = next_stamp_i;
    end else if (ctrl_i.load) begin
      stamp_d = load_stamp_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
  end

  assign stamp_o = stamp_q;

endmodule

`default_nettype wire

// File: rtl/sliding_window_rate_limiter.sv
// top level of the sliding window rate limiter
// a request is captured on transfer, then the expiry state pops stale stamps from the chain
// head, one stamp per cycle, and the result goes into the output register once none is left
//   and that register is free; no new request is taken until the current one has finished
// reset: asynchronous active low; clears count, sequencer and output valid, loads
//   max_per_window = 64 and window_ticks = 1000000; stamp cells are not cleared
`default_nettype none

module sliding_window_rate_limiter #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned STAMP_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [swrl_pkg::TIME_W-1:0]     s_axis_tdata,   // [31:0] time_now
  input  wire logic                            s_axis_tuser,   // [0] commit
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [swrl_pkg::OCC_BUS_W-1:0]  m_axis_tdata,   // [6:0] occupancy, [7] zero
  output logic                                 m_axis_tuser,   // [0] admitted
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [swrl_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  // width for comparing an age against the window register
  localparam int unsigned CmpW = (STAMP_BITS > swrl_pkg::WIN_W) ? STAMP_BITS
                                                                : swrl_pkg::WIN_W;
  // width for comparing the count against max_per_window
  localparam int unsigned AdmW = (CntW > swrl_pkg::MAX_W) ? CntW : swrl_pkg::MAX_W;

  // ---------------------------------------------------------------------------
  // configuration registers, always ready
  // ---------------------------------------------------------------------------
  logic [swrl_pkg::MAX_W-1:0] max_q;
  logic [swrl_pkg::WIN_W-1:0] window_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= swrl_pkg::MAX_RESET;
      window_q <= swrl_pkg::WIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        swrl_pkg::REG_MAX_PER_WINDOW: max_q    <= cfg_data_i[swrl_pkg::MAX_W-1:0];
        swrl_pkg::REG_WINDOW_TICKS:   window_q <= cfg_data_i[swrl_pkg::WIN_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request sequencer and stamp count
  // ---------------------------------------------------------------------------
  swrl_pkg::state_e state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [STAMP_BITS-1:0] now_q;
  logic                  commit_q;

  logic                  out_valid_q, out_valid_d;
  logic                  out_admit_q;
  logic [CntW-1:0]       out_count_q;

  logic [STAMP_BITS-1:0] head_stamp;
  logic [STAMP_BITS-1:0] age;
  logic                  expire;
  logic                  admit;
  logic                  out_free;
  logic                  finish;
  logic                  pop;
  logic                  push;

  assign s_axis_tready = (state_q == swrl_pkg::ST_IDLE);

  // modular age of the oldest stamp; the head cell always holds it
  assign age    = now_q - head_stamp;
  assign expire = (count_q != '0) && (CmpW'(age) > CmpW'(window_q));

  assign admit  = (AdmW'(count_q) < AdmW'(max_q)) && (count_q < CntW'(RING_DEPTH));

  // output register frees up when empty or when its transfer happens now
  assign out_free = !out_valid_q || m_axis_tready;

  assign pop    = (state_q == swrl_pkg::ST_EXPIRE) && expire;
  assign finish = (state_q == swrl_pkg::ST_EXPIRE) && !expire && out_free;
  assign push   = finish && admit && commit_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      swrl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = swrl_pkg::ST_EXPIRE;
        end
      end
      swrl_pkg::ST_EXPIRE: begin
        if (pop) begin
          count_d = count_q - CntW'(1);
        end else if (finish) begin
          state_d = swrl_pkg::ST_IDLE;
          if (push) begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      default: state_d = swrl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swrl_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // request payload capture
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      now_q    <= STAMP_BITS'(s_axis_tdata);
      commit_q <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // stamp cell chain: cell 0 is the oldest, pops shift every cell one place down
  // ---------------------------------------------------------------------------
  logic [STAMP_BITS-1:0] chain [RING_DEPTH];

  for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
    swrl_pkg::cell_ctrl_t  ctrl;
    logic [STAMP_BITS-1:0] next_stamp;

    assign ctrl.shift = pop;
    // append lands just past the youngest stored stamp
    assign ctrl.load  = push && (count_q[IdxW-1:0] == IdxW'(k));

    if (k == RING_DEPTH - 1) begin : g_tail
      assign next_stamp = '0;
    end else begin : g_body
      assign next_stamp = chain[k+1];
    end

    swrl_cell #(
      .STAMP_BITS(STAMP_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .next_stamp_i(next_stamp),
      .load_stamp_i(now_q),
      .stamp_o     (chain[k])
    );
  end

  assign head_stamp = chain[0];

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // occupancy reported after the append
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_admit_q <= admit;
      out_count_q <= push ? (count_q + CntW'(1)) : count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_admit_q;
  assign m_axis_tdata  = {1'b0, swrl_pkg::OCC_W'(out_count_q)};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RING_DEPTH))
    else $error("stamp count above chain depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> count_q != '0)
    else $error("pop from empty chain");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> count_q < CntW'(RING_DEPTH))
    else $error("append into full chain");

  a_accept_expire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q == swrl_pkg::ST_EXPIRE)
    else $error("accepted request not sent to expiry");

  a_finish_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> m_axis_tvalid)
    else $error("finished request did not produce a result");

endmodule

`default_nettype wire

// File: test/sliding_window_rate_limiter_checker.sv
// checker for the sliding window rate limiter: predicts each verdict and compares results
`timescale 1ns / 100ps

module sliding_window_rate_limiter_checker #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel as seen on the block
  input  logic                               req_valid_i,
  input  logic                               req_ready_i,
  input  logic [swrl_pkg::TIME_W-1:0]        req_data_i,    // [31:0] time_now
  input  logic                               req_user_i,    // [0] commit
  // result channel as seen on the block
  input  logic                               res_valid_i,
  input  logic                               res_ready_i,
  input  logic [swrl_pkg::OCC_BUS_W-1:0]     res_data_i,    // [6:0] occupancy, [7] zero
  input  logic                               res_user_i,    // [0] admitted
  // configuration writes
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [swrl_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  output int unsigned                        pending_o,
  output int unsigned                        error_count_o
);
  import swrl_pkg::*;

  typedef struct packed {
    logic             admitted;
    logic [OCC_W-1:0] occupancy;
  } limit_verdict_t;

  // own copy of the limiter state and its registers
  logic [MAX_W-1:0]  lim_max;
  logic [WIN_W-1:0]  lim_window;
  logic [TIME_W-1:0] stamps [RING_DEPTH];
  int unsigned       oldest;
  int unsigned       stamp_total;

  limit_verdict_t    verdicts_due [$];
  int unsigned       errors;

  // expire stale stamps from the oldest end, then admit and maybe record
  function automatic limit_verdict_t admit_request(logic [TIME_W-1:0] now, logic commit);
    limit_verdict_t v;
    logic [TIME_W-1:0] age;
    logic kept;
    kept = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (stamp_total != 0 && !kept) begin
        age = now - stamps[oldest];
        if (age > lim_window) begin
          oldest = (oldest + 1) % RING_DEPTH;
          stamp_total--;
        end else begin
          kept = 1'b1;
        end
      end
    end
    v.admitted = (stamp_total < lim_max) && (stamp_total < RING_DEPTH);
    if (v.admitted && commit) begin
      stamps[(oldest + stamp_total) % RING_DEPTH] = now;
      stamp_total++;
    end
    v.occupancy = stamp_total[OCC_W-1:0];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    limit_verdict_t want;
    if (!rst_ni) begin
      lim_max     = MAX_RESET;
      lim_window  = WIN_RESET;
      oldest      = 0;
      stamp_total = 0;
      errors      = 0;
      for (int i = 0; i < RING_DEPTH; i++) stamps[i] = '0;
      verdicts_due.delete();
      pending_o     <= 0;
      error_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_PER_WINDOW: lim_max = cfg_data_i[MAX_W-1:0];
          REG_WINDOW_TICKS:   lim_window = cfg_data_i[WIN_W-1:0];
          default: ;  // unknown index, write dropped
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $error("result: expected none, actual admitted %0d occupancy %0d",
                 res_user_i, res_data_i[OCC_W-1:0]);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (res_user_i !== want.admitted) begin
            $error("admitted: expected %0d, actual %0d", want.admitted, res_user_i);
            errors++;
          end
          if (res_data_i[OCC_W-1:0] !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy,
                   res_data_i[OCC_W-1:0]);
            errors++;
          end
          if (res_data_i[OCC_BUS_W-1:OCC_W] !== '0) begin
            $error("pad: expected 0, actual %0d", res_data_i[OCC_BUS_W-1:OCC_W]);
            errors++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        verdicts_due.insert(verdicts_due.size(), admit_request(req_data_i, req_user_i));
      end
      pending_o     <= verdicts_due.size();
      error_count_o <= errors;
    end
  end

endmodule

// File: test/sliding_window_rate_limiter_tb.sv
// testbench top of the sliding window rate limiter: stimulus, back pressure and verdict
`timescale 1ns / 100ps

module sliding_window_rate_limiter_tb;
  import swrl_pkg::*;

  localparam int unsigned RING_DEPTH    = 64;
  localparam int unsigned PHASE_ITEMS   = 125;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  // an index that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TIME_W-1:0]    s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OCC_BUS_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i    = '0;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycles   = 0;
  int unsigned rx_wait  = 0;
  bit          rx_burst = 1'b0;
  bit          tx_burst = 1'b0;

  sliding_window_rate_limiter #(
    .RING_DEPTH(RING_DEPTH),
    .STAMP_BITS(TIME_W)
  ) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  sliding_window_rate_limiter_checker #(.RING_DEPTH(RING_DEPTH)) u_checker (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid), .req_ready_i(s_axis_tready),
    .req_data_i(s_axis_tdata),   .req_user_i(s_axis_tuser),
    .res_valid_i(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_data_i(m_axis_tdata),   .res_user_i(m_axis_tuser),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .error_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random back pressure after each transfer, with stall-free stretches
  always @(posedge clk_i) begin : result_sink
    int unsigned w;
    if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
      w = rx_burst ? 0 : $urandom_range(0, 19);
      rx_wait       <= w;
      m_axis_tready <= (w == 0);
    end else if (!m_axis_tready) begin
      if (rx_wait <= 1) begin
        rx_wait       <= 0;
        m_axis_tready <= 1'b1;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  // one request transfer after a random gap; valid stays high if the next has no gap
  task automatic send_request(logic [TIME_W-1:0] t, logic commit);
    int unsigned gap;
    if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    s_axis_tuser  <= commit;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data, bit more);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (!more) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_limits(logic [MAX_W-1:0] max_adm, logic [WIN_W-1:0] win);
    write_reg(REG_MAX_PER_WINDOW, CFG_DAT_W'(max_adm), 1'b1);
    write_reg(REG_WINDOW_TICKS, win, 1'b0);
  endtask

  // block idle once every verdict has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // advance the tick: mostly small steps scaled to the window, some exact
  // window boundaries, repeats and jumps anywhere on the counter
  function automatic logic [TIME_W-1:0] next_tick(logic [TIME_W-1:0] t, logic [WIN_W-1:0] win);
    int unsigned pick;
    int unsigned span;
    logic [TIME_W-1:0] n;
    pick = $urandom_range(0, 99);
    span = (win > 32'h0FFF_FFFF) ? 32'h00FF_FFFF : win / 16 + 1;
    if (pick < 5)       n = $urandom();
    else if (pick < 15) n = t;
    else if (pick < 19) n = t + win;
    else if (pick < 22) n = t + win + 1;
    else                n = t + $urandom_range(0, span);
    return n;
  endfunction

  initial begin
    logic [TIME_W-1:0] tick;
    logic [MAX_W-1:0]  ph_max;
    logic [WIN_W-1:0]  ph_win;
    tick = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tight limit: expiry, rejection, counter wrap
    set_limits(7'd2, 32'd10);
    send_request(32'd0, 1'b1);
    send_request(32'd5, 1'b1);
    send_request(32'd6, 1'b1);
    send_request(32'd11, 1'b0);
    send_request(32'd15, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b1);
    send_request(32'd3, 1'b1);
    send_request(32'd0, 1'b1);

    // zero window: only equal stamps survive
    wait_idle();
    write_reg(REG_WINDOW_TICKS, 32'd0, 1'b0);
    send_request(32'd100, 1'b1);
    send_request(32'd100, 1'b1);
    send_request(32'd100, 1'b1);
    send_request(32'd101, 1'b0);

    // zero limit rejects everything
    wait_idle();
    write_reg(REG_MAX_PER_WINDOW, 32'd0, 1'b0);
    send_request(32'd200, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b0);

    // write to an unmapped index must leave the limit at zero
    wait_idle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF, 1'b0);
    send_request(32'd300, 1'b1);

    // back to reset values; age exactly equal to the window is kept
    wait_idle();
    set_limits(MAX_RESET, WIN_RESET);
    send_request(32'd0, 1'b1);
    send_request(32'd1000000, 1'b1);
    send_request(32'd1000001, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ph_max = 7'd127; ph_win = 32'hFFFF_FFFF; end  // limit above ring depth
        1: begin ph_max = 7'd64;  ph_win = 32'd1000;      end
        2: begin ph_max = 7'd1;   ph_win = 32'd50;        end
        3: begin ph_max = 7'd5;   ph_win = 32'd300;       end
        4: begin ph_max = 7'd0;   ph_win = 32'd100;       end
        5: begin ph_max = 7'd33;  ph_win = 32'd2000;      end
        6: begin ph_max = 7'd64;  ph_win = 32'd0;         end
        default: begin ph_max = 7'd10; ph_win = 32'h8000_0000; end
      endcase
      wait_idle();
      set_limits(ph_max, ph_win);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        tick = next_tick(tick, ph_win);
        send_request(tick, $urandom_range(0, 9) != 0);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
